FILE: design/smpd_pkg.sv
// ----------------------------------------------------------------------------
// smpd_pkg
// Shared types and constants for the serial mouse packet decoder.
// ----------------------------------------------------------------------------
package smpd_pkg;

    // header detection
    localparam logic [7:0] HDR_MASK  = 8'hF8;
    localparam logic [7:0] HDR_VALUE = 8'h80;

    // frame sizes and the saturating byte counter limit
    localparam int unsigned FRAME_MAX    = 5;
    localparam logic [2:0]  FILL_SHORT   = 3'd3;
    localparam logic [2:0]  FILL_LONG    = 3'd5;
    localparam logic [2:0]  SINCE_SAT    = 3'd6;
    localparam logic [2:0]  SINCE_LONG   = 3'd5;

    // header button bits (active low)
    localparam int unsigned HB_RIGHT  = 0;
    localparam int unsigned HB_MIDDLE = 1;
    localparam int unsigned HB_LEFT   = 2;

    // event work list positions, in output order
    localparam int unsigned STEP_LEFT   = 0;
    localparam int unsigned STEP_MIDDLE = 1;
    localparam int unsigned STEP_RIGHT  = 2;
    localparam int unsigned STEP_PAIR1  = 3;
    localparam int unsigned STEP_PAIR2  = 4;
    localparam int unsigned NUM_STEPS   = 5;

    // queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration port
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic REG_SCROLL_EMU = 1'b0;
    localparam logic REG_INVERT     = 1'b1;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_MOVE    = 2'd2,
        EV_SCROLL  = 2'd3
    } event_kind_t;

    typedef enum logic [1:0] {
        BID_LEFT   = 2'd0,
        BID_MIDDLE = 2'd1,
        BID_RIGHT  = 2'd2,
        BID_NONE   = 2'd3
    } button_id_t;

    // one complete frame, ready for event generation
    typedef struct packed {
        logic [NUM_STEPS-1:0] mask;
        logic [2:0]           now_btn;
        logic                 scroll;
        logic                 invert;
        logic [7:0]           dx1;
        logic [7:0]           dy1;
        logic [7:0]           dx2;
        logic [7:0]           dy2;
    } job_t;

    // front to queue handshake
    typedef struct packed {
        logic push;
        logic full;
    } qctl_t;

    function automatic logic [7:0] neg8(input logic [7:0] v);
        neg8 = 8'(8'd0 - v);
    endfunction

endpackage

FILE: design/serial_mouse_packet_decoder.sv
// ----------------------------------------------------------------------------
// serial_mouse_packet_decoder
// Serial mouse byte stream in, button and motion events out.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the two-entry job queue has room; the
//   back end loads a job, then emits its 1 to 5 event beats in order, holding
//   each beat while the output is not ready.
// Path: the first event of a frame passes the queue write, then the job load,
//   then the output register.
// Reset: async active low; frame sync, format, button history and queue clear,
//   scroll_emulation resets to 1, invert_scroll to 0.
module serial_mouse_packet_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata,   // [1:0] button_id,
                                                          // [9:2] x_amount,
                                                          // [17:10] y_amount
    output logic [1:0]                    m_axis_tuser,   // [1:0] event_kind
    output logic                          m_axis_tlast,   // last_event
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [smpd_pkg::PADDR_W-1:0]  paddr,
    input  logic [smpd_pkg::PDATA_W-1:0]  pwdata,
    output logic [smpd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import smpd_pkg::*;

    logic       scroll_emu_reg;
    logic       invert_reg;
    logic       cfg_write;

    logic       job_push;
    job_t       front_job;
    job_t       head_job;
    qctl_t      qctl;
    logic       queue_full;
    logic       head_valid;
    logic       pop;
    logic [1:0] event_kind;
    logic [1:0] button_id;
    logic [7:0] x_amount;
    logic [7:0] y_amount;
    logic       last_event;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_emu_reg <= 1'b1;
            invert_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_SCROLL_EMU)
            begin
                scroll_emu_reg <= pwdata[0];
            end
            else
            begin
                invert_reg <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_INVERT) ? PDATA_W'(invert_reg)
                                             : PDATA_W'(scroll_emu_reg);

    // front end
    smpd_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .byte_valid       (s_axis_tvalid),
        .byte_ready       (s_axis_tready),
        .rx_byte          (s_axis_tdata),
        .scroll_emulation (scroll_emu_reg),
        .invert_scroll    (invert_reg),
        .queue_full       (queue_full),
        .job_push         (job_push),
        .job              (front_job)
    );

    // job queue
    assign qctl.push = job_push;
    assign qctl.full = queue_full;

    smpd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl_in     (qctl),
        .full       (queue_full),
        .push_job   (front_job),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // back end
    smpd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .ev_valid   (m_axis_tvalid),
        .ev_ready   (m_axis_tready),
        .event_kind (event_kind),
        .button_id  (button_id),
        .x_amount   (x_amount),
        .y_amount   (y_amount),
        .last_event (last_event)
    );

    // output beat packing
    assign m_axis_tdata = {6'd0, y_amount, x_amount, button_id};
    assign m_axis_tuser = event_kind;
    assign m_axis_tlast = last_event;

    // a job is never offered to a full queue
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !queue_full)
        else $error("job pushed into full queue");

    // button events carry no motion
    a_button_no_motion: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == EV_PRESS || m_axis_tuser == EV_RELEASE))
        |-> (x_amount == 8'd0 && y_amount == 8'd0 && button_id != BID_NONE))
        else $error("button event with motion data");

    // motion events are never empty and carry button_id BID_LEFT
    a_motion_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == EV_MOVE || m_axis_tuser == EV_SCROLL))
        |-> ((x_amount != 8'd0 || y_amount != 8'd0) && button_id == BID_LEFT))
        else $error("empty or tagged motion event");

endmodule

FILE: design/smpd_front.sv
// ----------------------------------------------------------------------------
// smpd_front
// Byte intake: header sync, format detection, frame buffering and frame
// classification into a job with its list of events to emit.
// ----------------------------------------------------------------------------
module smpd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  logic [7:0]        rx_byte,
    input  logic              scroll_emulation,
    input  logic              invert_scroll,
    input  logic              queue_full,
    output logic              job_push,
    output smpd_pkg::job_t    job
);
    import smpd_pkg::*;

    logic [7:0] frame_reg [FRAME_MAX];
    logic [2:0] fill_reg, fill_next;
    logic [2:0] since_reg, since_next;
    logic       five_reg, five_next;
    logic [2:0] last_btn_reg, last_btn_next;

    logic       accept;
    logic       is_hdr;
    logic       take_data;
    logic [2:0] new_fill;
    logic       flush;
    logic [7:0] view [FRAME_MAX];
    logic [2:0] now_btn;
    logic [2:0] diff;

    assign byte_ready = !queue_full;
    assign accept     = byte_valid && byte_ready;

    // classify the byte and form the frame view including this byte
    always_comb
    begin
        is_hdr    = (rx_byte & HDR_MASK) == HDR_VALUE;
        take_data = !is_hdr && (fill_reg != 3'd0) && (fill_reg < FILL_LONG);
        new_fill  = take_data ? 3'(fill_reg + 3'd1) : fill_reg;
        for (int j = 0; j < FRAME_MAX; j++)
        begin
            view[j] = (take_data && (fill_reg == 3'(j))) ? rx_byte : frame_reg[j];
        end
        flush = (is_hdr || take_data) &&
                (((new_fill == FILL_SHORT) && !five_reg) || (new_fill == FILL_LONG));
        now_btn = view[0][2:0];
        diff    = now_btn ^ last_btn_reg;

        job.now_btn = now_btn;
        job.scroll  = scroll_emulation && !view[0][HB_MIDDLE];
        job.invert  = invert_scroll;
        job.dx1     = view[1];
        job.dy1     = view[2];
        job.dx2     = view[3];
        job.dy2     = view[4];
        job.mask[STEP_LEFT]   = diff[HB_LEFT];
        job.mask[STEP_MIDDLE] = diff[HB_MIDDLE];
        job.mask[STEP_RIGHT]  = diff[HB_RIGHT];
        job.mask[STEP_PAIR1]  = (view[1] != 8'd0) || (view[2] != 8'd0);
        job.mask[STEP_PAIR2]  = (new_fill == FILL_LONG) &&
                                ((view[3] != 8'd0) || (view[4] != 8'd0));
        job_push = accept && flush && (job.mask != '0);
    end

    // next values of the sync state
    always_comb
    begin
        since_next    = since_reg;
        fill_next     = fill_reg;
        five_next     = five_reg;
        last_btn_next = last_btn_reg;
        if (accept)
        begin
            since_next = (since_reg < SINCE_SAT) ? 3'(since_reg + 3'd1) : since_reg;
            if (flush)
            begin
                last_btn_next = now_btn;
                fill_next     = 3'd0;
            end
            if (is_hdr)
            begin
                fill_next  = 3'd1;
                five_next  = (since_next == SINCE_LONG);
                since_next = 3'd0;
            end
            else if (take_data && !flush)
            begin
                fill_next = new_fill;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            since_reg    <= 3'd0;
            fill_reg     <= 3'd0;
            five_reg     <= 1'b0;
            last_btn_reg <= 3'd0;
        end
        else
        begin
            since_reg    <= since_next;
            fill_reg     <= fill_next;
            five_reg     <= five_next;
            last_btn_reg <= last_btn_next;
        end
    end

    // frame byte buffer
    always_ff @(posedge clk)
    begin
        if (accept && is_hdr)
        begin
            frame_reg[0] <= rx_byte;
        end
        else if (accept && take_data)
        begin
            frame_reg[fill_reg] <= rx_byte;
        end
    end

endmodule

FILE: design/smpd_queue.sv
// ----------------------------------------------------------------------------
// smpd_queue
// Small register queue of frame jobs between the front and the back.
// ----------------------------------------------------------------------------
module smpd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  smpd_pkg::qctl_t   ctl_in,
    output logic              full,
    input  smpd_pkg::job_t    push_job,
    input  logic              pop,
    output logic              head_valid,
    output smpd_pkg::job_t    head_job
);
    import smpd_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        do_push     = ctl_in.push && !ctl_in.full;
        do_pop      = pop && head_valid;
        wr_ptr_next = do_push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: design/smpd_back.sv
// ----------------------------------------------------------------------------
// smpd_back
// Event sequencer: walks the pending event list of one job, one event per
// cycle while the output register is free or being read, into an output register.
// ----------------------------------------------------------------------------
module smpd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  smpd_pkg::job_t    head_job,
    output logic              pop,
    output logic              ev_valid,
    input  logic              ev_ready,
    output logic [1:0]        event_kind,
    output logic [1:0]        button_id,
    output logic [7:0]        x_amount,
    output logic [7:0]        y_amount,
    output logic              last_event
);
    import smpd_pkg::*;

    job_t                 cur_reg;
    logic [NUM_STEPS-1:0] mask_reg, mask_next;
    logic                 out_valid_reg;
    event_kind_t          kind_reg;
    button_id_t           bid_reg;
    logic [7:0]           x_reg;
    logic [7:0]           y_reg;
    logic                 last_reg;

    logic [NUM_STEPS-1:0] sel;
    logic                 emit;
    event_kind_t          kind_c;
    button_id_t           bid_c;
    logic [7:0]           x_c;
    logic [7:0]           y_c;
    logic [7:0]           dx;
    logic [7:0]           dy;

    // pick the lowest pending event
    always_comb
    begin
        sel = '0;
        priority if (mask_reg[STEP_LEFT])
            sel[STEP_LEFT] = 1'b1;
        else if (mask_reg[STEP_MIDDLE])
            sel[STEP_MIDDLE] = 1'b1;
        else if (mask_reg[STEP_RIGHT])
            sel[STEP_RIGHT] = 1'b1;
        else if (mask_reg[STEP_PAIR1])
            sel[STEP_PAIR1] = 1'b1;
        else if (mask_reg[STEP_PAIR2])
            sel[STEP_PAIR2] = 1'b1;
    end

    // build the selected event
    always_comb
    begin
        dx = sel[STEP_PAIR2] ? cur_reg.dx2 : cur_reg.dx1;
        dy = sel[STEP_PAIR2] ? cur_reg.dy2 : cur_reg.dy1;
        kind_c = EV_MOVE;
        bid_c  = BID_LEFT;
        x_c    = 8'd0;
        y_c    = 8'd0;
        if (sel[STEP_LEFT])
        begin
            kind_c = cur_reg.now_btn[HB_LEFT] ? EV_RELEASE : EV_PRESS;
        end
        else if (sel[STEP_MIDDLE])
        begin
            kind_c = cur_reg.now_btn[HB_MIDDLE] ? EV_RELEASE : EV_PRESS;
            bid_c  = BID_MIDDLE;
        end
        else if (sel[STEP_RIGHT])
        begin
            kind_c = cur_reg.now_btn[HB_RIGHT] ? EV_RELEASE : EV_PRESS;
            bid_c  = BID_RIGHT;
        end
        else if (!cur_reg.scroll)
        begin
            kind_c = EV_MOVE;
            x_c    = dx;
            y_c    = neg8(dy);
        end
        else
        begin
            kind_c = EV_SCROLL;
            x_c    = cur_reg.invert ? neg8(dx) : dx;
            y_c    = cur_reg.invert ? neg8(dy) : dy;
        end
    end

    // sequencing control
    always_comb
    begin
        pop       = (mask_reg == '0) && head_valid;
        emit      = (mask_reg != '0) && (!out_valid_reg || ev_ready);
        mask_next = mask_reg;
        if (pop)
        begin
            mask_next = head_job.mask;
        end
        else if (emit)
        begin
            mask_next = mask_reg & ~sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (ev_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // job and output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_job;
        end
        if (emit)
        begin
            kind_reg <= kind_c;
            bid_reg  <= bid_c;
            x_reg    <= x_c;
            y_reg    <= y_c;
            last_reg <= (mask_reg & ~sel) == '0;
        end
    end

    assign ev_valid   = out_valid_reg;
    assign event_kind = kind_reg;
    assign button_id  = bid_reg;
    assign x_amount   = x_reg;
    assign y_amount   = y_reg;
    assign last_event = last_reg;

endmodule
